FILE: sv/crt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_pkg
// Shared widths, command and status codes and word types of the chunk
// reassembly tracker.
// ----------------------------------------------------------------------------
package crt_pkg;

  localparam int CMD_W      = 2;
  localparam int SEQ_W      = 12;
  localparam int STATUS_W   = 3;
  localparam int DCT_W      = 12;
  localparam int FBT_W      = 20;
  localparam int OFF_W      = 20;
  localparam int LEN_W      = 9;
  localparam int TOT_W      = 13;
  localparam int EPOCH_W    = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 48;

  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CHUNK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FINAL = 2'd2;
  localparam logic [CMD_W-1:0] CMD_ABORT = 2'd3;

  localparam logic [STATUS_W-1:0] STS_ACCEPTED   = 3'd0;
  localparam logic [STATUS_W-1:0] STS_DUPLICATE  = 3'd1;
  localparam logic [STATUS_W-1:0] STS_RANGE      = 3'd2;
  localparam logic [STATUS_W-1:0] STS_NOT_ACTIVE = 3'd3;
  localparam logic [STATUS_W-1:0] STS_INCOMPLETE = 3'd4;
  localparam logic [STATUS_W-1:0] STS_STARTED    = 3'd5;
  localparam logic [STATUS_W-1:0] STS_FINALIZED  = 3'd6;
  localparam logic [STATUS_W-1:0] STS_ABORTED    = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_DCT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FBT = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [SEQ_W-1:0] seq;
    logic             in_range;
    logic             is_last;
    logic [OFF_W-1:0] offset;
  } crt_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                we;
    logic [OFF_W-1:0]    offset;
    logic [LEN_W-1:0]    length;
    logic [TOT_W-1:0]    total;
    logic                complete;
    logic                active;
  } crt_result_t;

endpackage

FILE: sv/chunk_reassembly_tracker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_reassembly_tracker_unit
// Tracks out-of-order chunk arrival for one transfer session.
// ----------------------------------------------------------------------------
// Each command word gives exactly one result word. The front classifies a
// word in the cycle it is taken and parks it in a two-entry queue; the back
// then handles start, finalize, abort and rejected chunks in its idle state,
// and a chunk that reaches the bitmap by a registered read, then a write.
// The bitmap holds an epoch tag per chunk, so a start costs no clearing. The
// back sweeps the whole bitmap after reset, and again on the start that finds
// the tags used up (the 256th start after reset, then every 255th), while
// words queue up at the front. A result waiting in the output register stalls
// the back; input is held off once both queue entries are taken.
module chunk_reassembly_tracker_unit import crt_pkg::*; #(
  parameter int unsigned MAX_CHUNKS  = 4096,
  parameter int unsigned CHUNK_BYTES = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // sequence_req, pad
  input  logic [CMD_W-1:0]      s_axis_tuser,   // command
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // write_enable, byte_offset,
                                                // byte_length, received_total,
                                                // complete, session_active, pad
  output logic [STATUS_W-1:0]   m_axis_tuser    // status
);

  crt_item_t                      fe_item, q_item;
  logic                           q_full, q_valid, q_pop;
  logic [DCT_W-1:0]               dct;
  logic [$clog2(CHUNK_BYTES)-1:0] last_rem;
  crt_result_t                    res;

  crt_front #(
    .MAX_CHUNKS  (MAX_CHUNKS),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (s_axis_tuser),
    .seq_i      (s_axis_tdata[SEQ_W-1:0]),
    .item_o     (fe_item),
    .dct_o      (dct),
    .last_rem_o (last_rem)
  );

  crt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid),
    .item_i  (fe_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (q_item),
    .valid_o (q_valid)
  );

  assign s_axis_tready = !q_full;

  crt_back #(
    .MAX_CHUNKS  (MAX_CHUNKS),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (q_item),
    .pop_o        (q_pop),
    .dct_i        (dct),
    .last_rem_i   (last_rem),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .result_o     (res)
  );

  assign m_axis_tuser = res.status;
  assign m_axis_tdata = {3'b000, res.active, res.complete, res.total,
                         res.length, res.offset, res.we};

endmodule

FILE: sv/crt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module crt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: sv/crt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_front
// Configuration registers, last-chunk remainder unit and stateless
// classification of incoming command words.
// ----------------------------------------------------------------------------
module crt_front import crt_pkg::*; #(
  parameter int unsigned MAX_CHUNKS  = 4096,
  parameter int unsigned CHUNK_BYTES = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [CFG_IDX_W-1:0]             cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]            cfg_data_i,
  input  logic [CMD_W-1:0]                 cmd_i,
  input  logic [SEQ_W-1:0]                 seq_i,
  output crt_item_t                        item_o,
  output logic [DCT_W-1:0]                 dct_o,
  output logic [$clog2(CHUNK_BYTES)-1:0]   last_rem_o
);

  localparam int LOG_C = $clog2(CHUNK_BYTES);
  localparam int REC_S = FBT_W + LOG_C;
  localparam int REC_W = FBT_W + 2;
  localparam int PW    = FBT_W + REC_W;
  localparam int QW    = PW - REC_S;
  localparam int QCW   = QW + LOG_C + 1;
  localparam longint unsigned REC_M =
    ((64'd1 << REC_S) + 64'(CHUNK_BYTES) - 64'd1) / 64'(CHUNK_BYTES);

  logic [DCT_W-1:0] dct_q;
  logic [FBT_W-1:0] fbt_q;
  logic [QW-1:0]    quot_q, quot_d;
  logic [LOG_C-1:0] rem_q;
  logic [PW-1:0]    rec_prod;
  logic [QCW-1:0]   qc_prod;
  logic [FBT_W-1:0] rem_d;
  logic [31:0]      off_prod;

  // quotient by reciprocal multiply, exact over the whole 20-bit range
  assign rec_prod = PW'(cfg_data_i[FBT_W-1:0]) * PW'(REC_M);
  assign quot_d   = rec_prod[PW-1:REC_S];
  assign qc_prod  = QCW'(quot_q) * QCW'(CHUNK_BYTES);
  assign rem_d    = fbt_q - FBT_W'(qc_prod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dct_q  <= '0;
      fbt_q  <= '0;
      quot_q <= '0;
      rem_q  <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == REG_DCT) begin
        dct_q <= cfg_data_i[DCT_W-1:0];
      end
      if (cfg_we_i && cfg_idx_i == REG_FBT) begin
        fbt_q  <= cfg_data_i[FBT_W-1:0];
        quot_q <= quot_d;
      end
      rem_q <= rem_d[LOG_C-1:0];
    end
  end

  assign off_prod = 32'(seq_i - 12'd1) * 32'(CHUNK_BYTES);

  always_comb begin
    item_o.cmd      = cmd_i;
    item_o.seq      = seq_i;
    item_o.in_range = (seq_i != '0) && (seq_i <= dct_q) &&
                      (32'(seq_i) < 32'(MAX_CHUNKS));
    item_o.is_last  = (seq_i == dct_q);
    item_o.offset   = off_prod[OFF_W-1:0];
  end

  assign dct_o      = dct_q;
  assign last_rem_o = rem_q;

endmodule

FILE: sv/crt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_queue
// Two-entry queue of classified words between front and back.
// ----------------------------------------------------------------------------
module crt_queue import crt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  crt_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output crt_item_t item_o,
  output logic      valid_o
);

  crt_item_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

FILE: sv/crt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_back
// Session state, epoch-tagged received bitmap and result register.
// ----------------------------------------------------------------------------
module crt_back import crt_pkg::*; #(
  parameter int unsigned MAX_CHUNKS  = 4096,
  parameter int unsigned CHUNK_BYTES = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           head_valid_i,
  input  crt_item_t                      head_i,
  output logic                           pop_o,
  input  logic [DCT_W-1:0]               dct_i,
  input  logic [$clog2(CHUNK_BYTES)-1:0] last_rem_i,
  output logic                           m_valid_o,
  input  logic                           m_ready_i,
  output crt_result_t                    result_o
);

  localparam int AW    = $clog2(MAX_CHUNKS);
  localparam int LOG_C = $clog2(CHUNK_BYTES);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic [TOT_W-1:0]   count_q, count_d;
  logic               active_q, active_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic               out_valid_q, out_valid_d;
  crt_item_t          cur_q, cur_d;
  crt_result_t        res_q, res_d;

  logic               can_load, emit, hit;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr;
  logic [EPOCH_W-1:0] ram_wdata, ram_rdata;
  logic [AW+SEQ_W-1:0] head_seq_ext, cur_seq_ext;
  logic [LOG_C:0]     len_full;
  logic [STATUS_W-1:0] status;
  logic               wr_flag;

  assign can_load     = !out_valid_q || m_ready_i;
  assign head_seq_ext = (AW+SEQ_W)'(head_i.seq);
  assign cur_seq_ext  = (AW+SEQ_W)'(cur_q.seq);
  assign hit          = (ram_rdata == epoch_q);
  assign len_full     = (cur_q.is_last && last_rem_i != '0) ? {1'b0, last_rem_i}
                                                            : (LOG_C+1)'(CHUNK_BYTES);

  crt_ram #(
    .WIDTH (EPOCH_W),
    .DEPTH (MAX_CHUNKS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (head_seq_ext[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    epoch_d   = epoch_q;
    count_d   = count_q;
    active_d  = active_q;
    clr_d     = clr_q;
    cur_d     = cur_q;
    pop_o     = 1'b0;
    emit      = 1'b0;
    status    = STS_ACCEPTED;
    wr_flag   = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = cur_seq_ext[AW-1:0];
    ram_wdata = epoch_q;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        if (clr_q == AW'(MAX_CHUNKS - 1)) begin
          clr_d   = '0;
          epoch_d = '0;
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (head_valid_i) begin
          case (head_i.cmd)
            CMD_START: begin
              if (epoch_q == '1) begin
                // tags about to wrap: wipe the map first, same word retried
                state_d = ST_CLEAR;
              end else if (can_load) begin
                pop_o    = 1'b1;
                emit     = 1'b1;
                status   = STS_STARTED;
                epoch_d  = epoch_q + EPOCH_W'(1);
                count_d  = TOT_W'(1);
                active_d = 1'b1;
              end
            end
            CMD_CHUNK: begin
              if (!active_q || !head_i.in_range) begin
                if (can_load) begin
                  pop_o  = 1'b1;
                  emit   = 1'b1;
                  status = !active_q ? STS_NOT_ACTIVE : STS_RANGE;
                end
              end else begin
                pop_o   = 1'b1;
                ram_re  = 1'b1;
                cur_d   = head_i;
                state_d = ST_LOOK;
              end
            end
            CMD_FINAL: begin
              if (can_load) begin
                pop_o = 1'b1;
                emit  = 1'b1;
                if (!active_q) begin
                  status = STS_NOT_ACTIVE;
                end else if (count_q != TOT_W'(dct_i) + TOT_W'(1)) begin
                  status = STS_INCOMPLETE;
                end else begin
                  status   = STS_FINALIZED;
                  active_d = 1'b0;
                end
              end
            end
            default: begin
              if (can_load) begin
                pop_o    = 1'b1;
                emit     = 1'b1;
                status   = STS_ABORTED;
                active_d = 1'b0;
              end
            end
          endcase
        end
      end
      ST_LOOK: begin
        if (can_load) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
          if (hit) begin
            status = STS_DUPLICATE;
          end else begin
            status  = STS_ACCEPTED;
            wr_flag = 1'b1;
            ram_we  = 1'b1;
            count_d = count_q + TOT_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_d.status   = status;
    res_d.we       = wr_flag;
    res_d.offset   = wr_flag ? cur_q.offset : '0;
    res_d.length   = wr_flag ? LEN_W'(len_full) : '0;
    res_d.total    = count_d;
    res_d.active   = active_d;
    res_d.complete = active_d && (count_d == TOT_W'(dct_i) + TOT_W'(1));
  end

  assign out_valid_d = emit || (out_valid_q && !m_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      epoch_q     <= '0;
      count_q     <= '0;
      active_q    <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      epoch_q     <= epoch_d;
      count_q     <= count_d;
      active_q    <= active_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign m_valid_o = out_valid_q;
  assign result_o  = res_q;

endmodule

FILE: sv/crt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_checker
// Port-level checks of session bookkeeping across successive result words.
// ----------------------------------------------------------------------------
module crt_checker import crt_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [STATUS_W-1:0]   m_axis_tuser
);

  logic             s_acc, m_acc;
  logic [TOT_W-1:0] last_tot_q, tot;
  logic             last_act_q, act, cmpl, we;
  logic [3:0]       pend_q;

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;
  assign we    = m_axis_tdata[0];
  assign tot   = m_axis_tdata[42:30];
  assign cmpl  = m_axis_tdata[43];
  assign act   = m_axis_tdata[44];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_tot_q <= '0;
      last_act_q <= 1'b0;
      pend_q     <= '0;
    end else begin
      if (m_acc) begin
        last_tot_q <= tot;
        last_act_q <= act;
      end
      if (s_acc && !m_acc) begin
        pend_q <= pend_q + 4'd1;
      end else if (!s_acc && m_acc) begin
        pend_q <= pend_q - 4'd1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_acc |-> pend_q != 4'd0)
    else $error("result word without a pending command word");

  a_accept_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_acc && m_axis_tuser == STS_ACCEPTED |->
      we && last_act_q && act && tot == last_tot_q + TOT_W'(1))
    else $error("accepted chunk did not advance the count by one");

  a_reject_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_acc && (m_axis_tuser == STS_DUPLICATE || m_axis_tuser == STS_RANGE ||
              m_axis_tuser == STS_NOT_ACTIVE || m_axis_tuser == STS_INCOMPLETE) |->
      !we && tot == last_tot_q && act == last_act_q)
    else $error("rejected word changed session state");

  a_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_acc && (m_axis_tuser == STS_FINALIZED || m_axis_tuser == STS_ABORTED) |->
      !act && !cmpl && !we && tot == last_tot_q)
    else $error("closing word left the session open");

endmodule

bind chunk_reassembly_tracker_unit crt_checker u_crt_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the chunk reassembly tracker. A table of directed
// words covers reset state, range edges, duplicates, restart, finalize and
// abort. Random phases with changing register settings and flow control
// follow. Every result word is checked field by field against a tracker
// model kept in the bench, or against a value typed into the table.
// ----------------------------------------------------------------------------
module tb_top;
  import crt_pkg::*;

  localparam int MAP_DEPTH    = 4096;
  localparam int CHUNK_BYTES  = 256;
  localparam int QUIET_LIMIT  = 20000;
  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 106;

  typedef struct packed {
    logic              is_cfg;
    logic              typed;
    logic [CMD_W-1:0]  cmd;
    logic [SEQ_W-1:0]  seq;
    logic [DCT_W-1:0]  dct;
    logic [FBT_W-1:0]  fbt;
    crt_result_t       res;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = REG_DCT;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [CMD_W-1:0]      s_axis_tuser = CMD_START;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;

  // tracker model state
  logic [MAP_DEPTH-1:0]  seen_map = '0;
  logic [TOT_W-1:0]      got_count = '0;
  logic                  live = 1'b0;
  logic [DCT_W-1:0]      dct_r = '0;
  logic [FBT_W-1:0]      fbt_r = '0;

  crt_result_t           pending_results[$];
  plan_row_t             plan[$];
  int                    err_count = 0;
  int                    quiet_cycles = 0;
  int unsigned           send_gap_pct = 0;
  int unsigned           recv_stall_pct = 0;

  chunk_reassembly_tracker_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic all_received();
    return live && (got_count == TOT_W'(dct_r) + TOT_W'(1));
  endfunction

  function automatic crt_result_t track_command(input logic [CMD_W-1:0] cmd,
                                                input logic [SEQ_W-1:0] seq);
    crt_result_t      r;
    logic [FBT_W-1:0] tail;
    r = '0;
    case (cmd)
      CMD_START: begin
        seen_map    = '0;
        seen_map[0] = 1'b1;
        got_count   = TOT_W'(1);
        live        = 1'b1;
        r.status    = STS_STARTED;
      end
      CMD_CHUNK: begin
        if (!live) begin
          r.status = STS_NOT_ACTIVE;
        end else if (seq == '0 || seq > dct_r) begin
          r.status = STS_RANGE;
        end else if (seen_map[seq]) begin
          r.status = STS_DUPLICATE;
        end else begin
          seen_map[seq] = 1'b1;
          got_count     = got_count + TOT_W'(1);
          r.status      = STS_ACCEPTED;
          r.we          = 1'b1;
          r.offset      = OFF_W'((int'(seq) - 1) * CHUNK_BYTES);
          r.length      = LEN_W'(CHUNK_BYTES);
          tail          = fbt_r % FBT_W'(CHUNK_BYTES);
          if (seq == dct_r && tail != '0) r.length = LEN_W'(tail);
        end
      end
      CMD_FINAL: begin
        if (!live) begin
          r.status = STS_NOT_ACTIVE;
        end else if (!all_received()) begin
          r.status = STS_INCOMPLETE;
        end else begin
          live     = 1'b0;
          r.status = STS_FINALIZED;
        end
      end
      default: begin
        live     = 1'b0;
        r.status = STS_ABORTED;
      end
    endcase
    r.total    = got_count;
    r.complete = all_received();
    r.active   = live;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [DCT_W-1:0] dct,
                                        input logic [FBT_W-1:0] fbt);
    plan_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.dct    = dct;
    r.fbt    = fbt;
    return r;
  endfunction

  function automatic plan_row_t cmd_row(input logic [CMD_W-1:0] cmd,
                                        input logic [SEQ_W-1:0] seq);
    plan_row_t r;
    r     = '0;
    r.cmd = cmd;
    r.seq = seq;
    return r;
  endfunction

  function automatic plan_row_t known_row(input logic [CMD_W-1:0] cmd,
                                          input logic [SEQ_W-1:0] seq,
                                          input logic [STATUS_W-1:0] status,
                                          input logic we,
                                          input logic [OFF_W-1:0] offset,
                                          input logic [LEN_W-1:0] length,
                                          input logic [TOT_W-1:0] total,
                                          input logic complete,
                                          input logic active);
    plan_row_t r;
    r       = cmd_row(cmd, seq);
    r.typed = 1'b1;
    r.res   = '{status, we, offset, length, total, complete, active};
    return r;
  endfunction

  function automatic void compare_field(input string field, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      err_count++;
    end
  endfunction

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [SEQ_W-1:0] seq,
                           input logic typed, input crt_result_t known);
    crt_result_t r;
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'(seq);
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = track_command(cmd, seq);
    pending_results.push_back(typed ? known : r);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic write_regs(input logic [DCT_W-1:0] dct, input logic [FBT_W-1:0] fbt);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_DCT;
    cfg_data_i <= CFG_DATA_W'(dct);
    @(posedge clk_i);
    dct_r = dct;
    cfg_idx_i  <= REG_FBT;
    cfg_data_i <= CFG_DATA_W'(fbt);
    @(posedge clk_i);
    fbt_r = fbt;
    cfg_we_i   <= 1'b0;
  endtask

  task automatic pick_command(output logic [CMD_W-1:0] cmd, output logic [SEQ_W-1:0] seq);
    int unsigned r;
    r   = $urandom_range(99);
    seq = SEQ_W'($urandom_range(0, MAP_DEPTH - 1));
    if (!live) begin
      if (r < 75)      cmd = CMD_START;
      else if (r < 85) cmd = CMD_CHUNK;
      else if (r < 93) cmd = CMD_FINAL;
      else             cmd = CMD_ABORT;
    end else if (all_received() && r < 60) begin
      cmd = CMD_FINAL;
    end else begin
      if (r < 80)      cmd = CMD_CHUNK;
      else if (r < 88) cmd = CMD_FINAL;
      else if (r < 93) cmd = CMD_ABORT;
      else             cmd = CMD_START;
    end
    // mostly well-formed chunks, biased towards ones still missing
    if (cmd == CMD_CHUNK && live && dct_r != '0 && $urandom_range(99) < 85) begin
      seq = SEQ_W'($urandom_range(1, dct_r));
      if ($urandom_range(99) < 75) begin
        repeat (6) if (seen_map[seq]) seq = SEQ_W'($urandom_range(1, dct_r));
      end
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    crt_result_t got;
    crt_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tuser, m_axis_tdata[0], m_axis_tdata[20:1], m_axis_tdata[29:21],
              m_axis_tdata[42:30], m_axis_tdata[43], m_axis_tdata[44]};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %h", $time, got);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("status", want.status, got.status);
        compare_field("write_enable", want.we, got.we);
        compare_field("byte_offset", want.offset, got.offset);
        compare_field("byte_length", want.length, got.length);
        compare_field("received_total", want.total, got.total);
        compare_field("complete", want.complete, got.complete);
        compare_field("session_active", want.active, got.active);
      end
    end
  end

  // covers the bitmap sweep after reset and on the start that finds the tags used up
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [CMD_W-1:0] cmd;
    logic [SEQ_W-1:0] seq;
    logic [DCT_W-1:0] dct;
    logic [FBT_W-1:0] fbt;
    plan = '{
      cfg_row(12'd3, 20'd612),
      known_row(CMD_CHUNK, 12'd1, STS_NOT_ACTIVE, 0, 0, 0, 0, 0, 0),
      known_row(CMD_FINAL, 12'd0, STS_NOT_ACTIVE, 0, 0, 0, 0, 0, 0),
      known_row(CMD_ABORT, 12'd0, STS_ABORTED, 0, 0, 0, 0, 0, 0),
      known_row(CMD_START, 12'd0, STS_STARTED, 0, 0, 0, 1, 0, 1),
      known_row(CMD_CHUNK, 12'd0, STS_RANGE, 0, 0, 0, 1, 0, 1),
      known_row(CMD_CHUNK, 12'd4, STS_RANGE, 0, 0, 0, 1, 0, 1),
      known_row(CMD_CHUNK, 12'd4095, STS_RANGE, 0, 0, 0, 1, 0, 1),
      cmd_row(CMD_CHUNK, 12'd2),
      cmd_row(CMD_CHUNK, 12'd2),
      known_row(CMD_FINAL, 12'd0, STS_INCOMPLETE, 0, 0, 0, 2, 0, 1),
      cmd_row(CMD_CHUNK, 12'd3),
      cmd_row(CMD_CHUNK, 12'd1),
      cmd_row(CMD_FINAL, 12'd0),
      cmd_row(CMD_START, 12'd0),
      cmd_row(CMD_CHUNK, 12'd3),
      cmd_row(CMD_START, 12'd0),
      cmd_row(CMD_CHUNK, 12'd3),
      cmd_row(CMD_ABORT, 12'd0),
      cfg_row(12'd4095, 20'hFFFFF),
      cmd_row(CMD_START, 12'd0),
      known_row(CMD_CHUNK, 12'd4095, STS_ACCEPTED, 1, 20'd1048064, 9'd255, 2, 0, 1),
      known_row(CMD_CHUNK, 12'd4095, STS_DUPLICATE, 0, 0, 0, 2, 0, 1),
      cfg_row(12'd0, 20'd0),
      known_row(CMD_START, 12'd0, STS_STARTED, 0, 0, 0, 1, 1, 1),
      known_row(CMD_CHUNK, 12'd1, STS_RANGE, 0, 0, 0, 1, 1, 1),
      known_row(CMD_FINAL, 12'd0, STS_FINALIZED, 0, 0, 0, 1, 0, 0)
    };
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_regs(plan[i].dct, plan[i].fbt);
      end else begin
        send_word(plan[i].cmd, plan[i].seq, plan[i].typed, plan[i].res);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 3) begin
        dct = 12'd4095;
      end else if (phase == 5) begin
        dct = 12'd0;
      end else begin
        dct = DCT_W'($urandom_range(1, 12));
      end
      if (phase == 1) begin
        fbt = '0;
      end else if (phase == 6) begin
        fbt = 20'hFFFFF;
      end else if ($urandom_range(1) == 1) begin
        fbt = {12'($urandom_range(0, 4095)), 8'h00};
      end else begin
        fbt = FBT_W'($urandom);
      end
      write_regs(dct, fbt);
      case (phase % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 59; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 59; end
        default: begin send_gap_pct = 21; recv_stall_pct = 21; end
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (phase == 2 && n == PHASE_WORDS / 2) drain_results();
        pick_command(cmd, seq);
        send_word(cmd, seq, 1'b0, '0);
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
